// ----- rtl/lfu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // word index of the capacity register
    localparam logic [0:0] REG_CAPACITY = 1'b0;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_RESP
    } t_state;

    // how the recency ranks move in the update pass
    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_TOUCH,
        UPD_INSERT,
        UPD_EVICT
    } t_upd;

endpackage

`default_nettype wire

// ----- rtl/lfu_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface lfu_req_if;
    import lfu_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;

    modport source (output valid, opcode, key, value, input ready);
    modport sink (input valid, opcode, key, value, output ready);
endinterface

`default_nettype wire

// ----- rtl/lfu_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface lfu_rsp_if;
    import lfu_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;

    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

`default_nettype wire

// ----- rtl/lfu_cache_with_lru_ties.sv -----
`timescale 1ns / 1ps
`default_nettype none

// one item at a time: a scan pass over all ENTRIES slots through the registered memory read
// port, a decision state, a rank update pass when the item touches or inserts an entry, then
// a load of the result register, which waits while an earlier result is still not taken
// synchronous active-low reset clears valid marks, occupancy and control; capacity resets to 16
module lfu_cache_with_lru_ties #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    lfu_req_if.sink                           i_req,
    lfu_rsp_if.source                         o_rsp,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [lfu_pkg::APB_AW-1:0]   paddr,
    input  wire logic [lfu_pkg::APB_DW-1:0]   pwdata,
    output logic      [lfu_pkg::APB_DW-1:0]   prdata,
    output logic                              pready
);
    import lfu_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW = IW;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int CW = (OW > CAP_W) ? OW : CAP_W;
    localparam int NW = COUNT_BITS;

    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [IW:0]   N_SLOTS  = (IW + 1)'(ENTRIES);
    localparam logic [NW-1:0] CNT_MAX  = {NW{1'b1}};

    // storage
    logic [KEY_W-1:0]  r_mem_key  [ENTRIES];
    logic [DATA_W-1:0] r_mem_data [ENTRIES];
    logic [NW-1:0]     r_mem_cnt  [ENTRIES];
    logic [RW-1:0]     r_mem_rank [ENTRIES];
    logic [KEY_W-1:0]  r_key_q;
    logic [DATA_W-1:0] r_data_q;
    logic [NW-1:0]     r_cnt_q;
    logic [RW-1:0]     r_rank_q;

    logic [ENTRIES-1:0] r_valid;
    logic [OW-1:0]      r_occ;
    logic [CAP_W-1:0]   r_cap;

    t_state r_state, n_state;

    // sequencer
    logic [IW:0]   r_ptr;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic          rd_issue;
    logic [IW-1:0] rd_addr;
    logic          last_beat;

    // latched item
    logic              r_op;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_val;

    // scan results
    logic              r_found;
    logic [IW-1:0]     r_slot;
    logic [NW-1:0]     r_slot_cnt;
    logic [RW-1:0]     r_slot_rank;
    logic [DATA_W-1:0] r_hit_data;
    logic              r_have_v;
    logic [IW-1:0]     r_vic;
    logic [NW-1:0]     r_vic_cnt;
    logic [RW-1:0]     r_vic_rank;
    logic [KEY_W-1:0]  r_vic_key;
    logic              r_have_free;
    logic [IW-1:0]     r_free;

    // decision
    t_upd          d_mode;
    t_upd          r_mode;
    logic [IW-1:0] r_tgt;
    logic [RW-1:0] r_ref_rank;
    logic          r_ev;

    // result register
    logic              r_out_valid;
    logic              r_out_hit;
    logic [DATA_W-1:0] r_out_rdv;
    logic              r_out_ev;
    logic [KEY_W-1:0]  r_out_evk;

    logic req_ready;
    logic accept;
    logic resp_load;

    // ---------------- configuration port ----------------
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_CAPACITY);
    assign prdata = (paddr[APB_AW-1:2] == REG_CAPACITY) ? APB_DW'(r_cap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (cfg_wr) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    // ---------------- next state ----------------
    assign accept    = i_req.valid && req_ready;
    assign last_beat = r_rd_vld && (r_rd_idx == LAST_IDX);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (accept) n_state = ST_SCAN;
            ST_SCAN:   if (last_beat) n_state = ST_DECIDE;
            ST_DECIDE: n_state = (d_mode != UPD_NONE) ? ST_UPDATE : ST_RESP;
            ST_UPDATE: if (last_beat) n_state = ST_RESP;
            ST_RESP:   if (!r_out_valid || o_rsp.ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // ---------------- state outputs ----------------
    always_comb begin
        req_ready = 1'b0;
        rd_issue  = 1'b0;
        resp_load = 1'b0;
        unique case (r_state)
            ST_IDLE:   req_ready = i_rst_n;
            ST_SCAN:   rd_issue  = (r_ptr < N_SLOTS);
            ST_DECIDE: ;
            ST_UPDATE: rd_issue  = (r_ptr < N_SLOTS);
            ST_RESP:   resp_load = !r_out_valid || o_rsp.ready;
            default:   ;
        endcase
    end

    assign i_req.ready = req_ready;
    assign rd_addr     = r_ptr[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_issue;
            if (rd_issue) begin
                r_ptr <= r_ptr + 1'b1;
            end else if (r_state == ST_IDLE || r_state == ST_DECIDE) begin
                r_ptr <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= rd_addr;
    end

    // ---------------- memory read port ----------------
    always_ff @(posedge i_clk) begin
        r_key_q  <= r_mem_key[rd_addr];
        r_data_q <= r_mem_data[rd_addr];
        r_cnt_q  <= r_mem_cnt[rd_addr];
        r_rank_q <= r_mem_rank[rd_addr];
    end

    // ---------------- scan pass ----------------
    logic scan_beat;
    logic scan_v;
    logic better;

    assign scan_beat = (r_state == ST_SCAN) && r_rd_vld;
    assign scan_v    = r_valid[r_rd_idx];
    assign better    = !r_have_v || (r_cnt_q < r_vic_cnt) ||
                       ((r_cnt_q == r_vic_cnt) && (r_rank_q > r_vic_rank));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found     <= 1'b0;
            r_have_v    <= 1'b0;
            r_have_free <= 1'b0;
        end else if (accept) begin
            r_found     <= 1'b0;
            r_have_v    <= 1'b0;
            r_have_free <= 1'b0;
        end else if (scan_beat) begin
            if (scan_v && !r_found && (r_key_q == r_key)) begin
                r_found <= 1'b1;
            end
            if (scan_v && better) begin
                r_have_v <= 1'b1;
            end
            if (!scan_v) begin
                r_have_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_req.opcode;
            r_key <= i_req.key;
            r_val <= i_req.value;
        end
        if (scan_beat) begin
            if (scan_v && !r_found && (r_key_q == r_key)) begin
                r_slot      <= r_rd_idx;
                r_slot_cnt  <= r_cnt_q;
                r_slot_rank <= r_rank_q;
                r_hit_data  <= r_data_q;
            end
            if (scan_v && better) begin
                r_vic      <= r_rd_idx;
                r_vic_cnt  <= r_cnt_q;
                r_vic_rank <= r_rank_q;
                r_vic_key  <= r_key_q;
            end
            if (!scan_v && !r_have_free) begin
                r_free <= r_rd_idx;
            end
        end
    end

    // ---------------- decision ----------------
    logic [CW-1:0]      cap_ext;
    logic [CW-1:0]      cap_eff;
    logic               need_ev;
    logic [IW-1:0]      d_tgt;
    logic [RW-1:0]      d_ref;
    logic               d_ins;
    logic               d_wr_data;
    logic [NW-1:0]      d_cnt;
    logic [ENTRIES-1:0] n_valid;

    assign cap_ext = CW'(r_cap);
    assign cap_eff = (cap_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_ext;
    assign need_ev = (CW'(r_occ) >= cap_eff) && r_have_v;

    always_comb begin
        d_mode    = UPD_NONE;
        d_tgt     = r_slot;
        d_ref     = r_slot_rank;
        d_ins     = 1'b0;
        d_wr_data = 1'b0;
        d_cnt     = (r_slot_cnt == CNT_MAX) ? r_slot_cnt : r_slot_cnt + 1'b1;
        if (r_op == OP_GET) begin
            if (r_found) begin
                d_mode = UPD_TOUCH;
            end
        end else if (cap_eff != '0) begin
            if (r_found) begin
                d_mode    = UPD_TOUCH;
                d_wr_data = 1'b1;
            end else if (need_ev) begin
                // the freed victim slot competes with the first empty slot
                d_mode    = UPD_EVICT;
                d_ins     = 1'b1;
                d_wr_data = 1'b1;
                d_cnt     = NW'(1);
                d_ref     = r_vic_rank;
                d_tgt     = (r_have_free && (r_free < r_vic)) ? r_free : r_vic;
            end else if (r_have_free) begin
                d_mode    = UPD_INSERT;
                d_ins     = 1'b1;
                d_wr_data = 1'b1;
                d_cnt     = NW'(1);
                d_tgt     = r_free;
            end
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (d_mode == UPD_EVICT) begin
            n_valid[r_vic] = 1'b0;
        end
        if (d_ins) begin
            n_valid[d_tgt] = 1'b1;
        end
    end

    logic decide;
    assign decide = (r_state == ST_DECIDE);

    always_ff @(posedge i_clk) begin
        if (decide) begin
            if (d_mode != UPD_NONE) begin
                r_mem_cnt[d_tgt] <= d_cnt;
            end
            if (d_wr_data) begin
                r_mem_data[d_tgt] <= r_val;
            end
            if (d_ins) begin
                r_mem_key[d_tgt] <= r_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            r_ev    <= 1'b0;
            r_mode  <= UPD_NONE;
        end else if (decide) begin
            r_mode  <= d_mode;
            r_ev    <= (d_mode == UPD_EVICT);
            r_valid <= n_valid;
            if (d_mode == UPD_INSERT) begin
                r_occ <= r_occ + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (decide) begin
            r_tgt      <= d_tgt;
            r_ref_rank <= d_ref;
        end
    end

    // ---------------- rank update pass ----------------
    logic          upd_beat;
    logic [RW:0]   rank_ext;
    logic [RW:0]   rank_new;

    assign upd_beat = (r_state == ST_UPDATE) && r_rd_vld;
    assign rank_ext = {1'b0, r_rank_q};

    always_comb begin
        case (r_mode)
            UPD_TOUCH:  rank_new = (r_rank_q < r_ref_rank) ? rank_ext + 1'b1 : rank_ext;
            UPD_INSERT: rank_new = rank_ext + 1'b1;
            UPD_EVICT:  rank_new = (r_rank_q > r_ref_rank) ? rank_ext : rank_ext + 1'b1;
            default:    rank_new = rank_ext;
        endcase
        if (r_rd_idx == r_tgt) begin
            rank_new = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_beat && (r_valid[r_rd_idx] || r_rd_idx == r_tgt)) begin
            r_mem_rank[r_rd_idx] <= rank_new[RW-1:0];
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (resp_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (resp_load) begin
            r_out_hit <= r_found;
            r_out_rdv <= (r_op == OP_GET && r_found) ? r_hit_data : '0;
            r_out_ev  <= r_ev;
            r_out_evk <= r_ev ? r_vic_key : '0;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.read_value  = r_out_rdv;
    assign o_rsp.evicted     = r_out_ev;
    assign o_rsp.evicted_key = r_out_evk;

`ifndef SYNTHESIS
    a_occ_tracks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ == OW'($countones(r_valid)))
        else $error("occupancy out of step with valid marks");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == ST_SCAN)
        else $error("accepted beat did not start a scan");

    a_evict_only_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_ev |-> !r_out_hit)
        else $error("eviction reported on a hit");

    a_update_has_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_UPDATE |-> r_mode != UPD_NONE)
        else $error("rank pass without an update");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_lfu_cache_with_lru_ties.sv -----
`timescale 1ns / 1ps

module tb_lfu_cache_with_lru_ties;
    import lfu_pkg::*;

    localparam int N_ENT = 16;
    // narrow use counters so that saturation is reached within a short run
    localparam int CNT_W = 3;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam int REG_UNUSED  = 1;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_AFTER  = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int POOL_N      = 24;
    localparam int SEG_ITEMS   = 100;
    localparam int N_SEG       = 13;
    localparam int SEG_CAP [N_SEG] = '{16, 1, 8, 0, 31, 3, 12, 2, 16, 5, 20, 4, 16};

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_value;
        logic              evicted;
        logic [KEY_W-1:0]  evicted_key;
    } t_rsp;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // for a register row, key holds the register index and value the write data
    typedef struct packed {
        t_row_kind         kind;
        logic              op;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
        logic [7:0]        reps;
        logic              typed;
        t_rsp              want;
    } t_step;

    localparam t_rsp MISS     = '0;
    localparam t_rsp HIT_ZERO = '{1'b1, 32'h0, 1'b0, 32'h0};

    localparam int DIR_N = 28;
    localparam t_step DIR_TAB [DIR_N] = '{
        '{ROW_ITEM, OP_GET, 32'h0, 32'hDEAD_BEEF, 8'd1, 1'b1, MISS},
        '{ROW_ITEM, OP_PUT, 32'h0, 32'hFFFF_FFFF, 8'd1, 1'b1, MISS},
        '{ROW_ITEM, OP_GET, 32'h0, 32'h0, 8'd1, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
        '{ROW_ITEM, OP_PUT, 32'hFFFF_FFFF, 32'h0, 8'd1, 1'b1, MISS},
        '{ROW_ITEM, OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1, 1'b1, HIT_ZERO},
        '{ROW_ITEM, OP_PUT, 32'h0, 32'h1234_5678, 8'd1, 1'b1, HIT_ZERO},
        '{ROW_ITEM, OP_GET, 32'h0, 32'h0, 8'd1, 1'b1, '{1'b1, 32'h1234_5678, 1'b0, 32'h0}},
        // capacity zero, upper write bits set
        '{ROW_CFG, 1'b0, 32'(REG_CAPACITY), 32'hFFFF_FFE0, 8'd1, 1'b0, MISS},
        '{ROW_ITEM, OP_PUT, 32'h5, 32'h1, 8'd1, 1'b1, MISS},
        '{ROW_ITEM, OP_PUT, 32'h0, 32'h7, 8'd1, 1'b1, HIT_ZERO},
        '{ROW_ITEM, OP_GET, 32'h0, 32'h0, 8'd1, 1'b1, '{1'b1, 32'h1234_5678, 1'b0, 32'h0}},
        '{ROW_ITEM, OP_GET, 32'h5, 32'h0, 8'd1, 1'b1, MISS},
        '{ROW_CFG, 1'b0, 32'(REG_CAPACITY), 32'd2, 8'd1, 1'b0, MISS},
        '{ROW_ITEM, OP_PUT, 32'h10, 32'h3, 8'd1, 1'b0, MISS},
        '{ROW_ITEM, OP_PUT, 32'h11, 32'h4, 8'd1, 1'b0, MISS},
        // capacity below occupancy
        '{ROW_CFG, 1'b0, 32'(REG_CAPACITY), 32'd1, 8'd1, 1'b0, MISS},
        '{ROW_ITEM, OP_PUT, 32'h12, 32'h5, 8'd1, 1'b0, MISS},
        // write to an address with no register behind it
        '{ROW_CFG, 1'b0, 32'(REG_UNUSED), 32'd0, 8'd1, 1'b0, MISS},
        '{ROW_ITEM, OP_PUT, 32'h13, 32'h6, 8'd1, 1'b0, MISS},
        // capacity above the entry count
        '{ROW_CFG, 1'b0, 32'(REG_CAPACITY), 32'd31, 8'd1, 1'b0, MISS},
        '{ROW_ITEM, OP_GET, 32'h13, 32'h0, 8'd8, 1'b0, MISS},
        '{ROW_ITEM, OP_PUT, 32'h20, 32'h20, 8'd1, 1'b0, MISS},
        '{ROW_ITEM, OP_PUT, 32'h21, 32'h21, 8'd1, 1'b0, MISS},
        '{ROW_ITEM, OP_PUT, 32'h22, 32'h22, 8'd1, 1'b0, MISS},
        // count ties among the newest keys, oldest goes first
        '{ROW_CFG, 1'b0, 32'(REG_CAPACITY), 32'd4, 8'd1, 1'b0, MISS},
        '{ROW_ITEM, OP_PUT, 32'h23, 32'h23, 8'd1, 1'b0, MISS},
        '{ROW_ITEM, OP_PUT, 32'h24, 32'h24, 8'd1, 1'b0, MISS},
        '{ROW_CFG, 1'b0, 32'(REG_CAPACITY), 32'd16, 8'd1, 1'b0, MISS}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    lfu_req_if req_if ();
    lfu_rsp_if rsp_if ();

    lfu_cache_with_lru_ties #(
        .ENTRIES    (N_ENT),
        .COUNT_BITS (CNT_W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow copy of the cache contents
    logic              c_valid [N_ENT];
    logic [KEY_W-1:0]  c_key   [N_ENT];
    logic [DATA_W-1:0] c_data  [N_ENT];
    logic [CNT_W-1:0]  c_count [N_ENT];
    logic [3:0]        c_rank  [N_ENT];
    logic [4:0]        c_occ;
    logic [CAP_W-1:0]  c_cap;

    t_rsp pending_rsp [$];

    int src_idle_pct;
    int sink_idle_pct;
    int n_err;
    int n_req;
    int n_rsp;
    int n_hit;
    int n_evict;
    int n_cfg;
    int quiet_cycles;
    int hold_left;
    bit hold_done;

    // entry becomes most recent, newer entries age by one
    function automatic void touch_slot(int s);
        int i;
        logic [3:0] r0;
        r0 = c_rank[s];
        for (i = 0; i < N_ENT; i++)
            if (c_valid[i] && i != s && c_rank[i] < r0) c_rank[i]++;
        c_rank[s] = 4'd0;
        if (c_count[s] != CNT_MAX) c_count[s]++;
    endfunction

    function automatic t_rsp cache_access(logic op, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
        t_rsp r;
        int cap_eff;
        bit found;
        bit have;
        int slot;
        int vic;
        int fs;
        int i;
        logic [3:0] r0;
        r = '0;
        cap_eff = (c_cap > N_ENT) ? N_ENT : int'(c_cap);
        found = 1'b0;
        slot = 0;
        for (i = 0; i < N_ENT; i++)
            if (!found && c_valid[i] && c_key[i] == k) begin
                found = 1'b1;
                slot = i;
            end
        if (op == OP_GET) begin
            if (found) begin
                r.read_value = c_data[slot];
                touch_slot(slot);
            end
        end else if (cap_eff != 0) begin
            if (found) begin
                c_data[slot] = v;
                touch_slot(slot);
            end else begin
                if (c_occ >= cap_eff) begin
                    have = 1'b0;
                    vic = 0;
                    for (i = 0; i < N_ENT; i++)
                        if (c_valid[i] && (!have || c_count[i] < c_count[vic] ||
                            (c_count[i] == c_count[vic] && c_rank[i] > c_rank[vic]))) begin
                            have = 1'b1;
                            vic = i;
                        end
                    if (have) begin
                        r.evicted = 1'b1;
                        r.evicted_key = c_key[vic];
                        c_valid[vic] = 1'b0;
                        r0 = c_rank[vic];
                        for (i = 0; i < N_ENT; i++)
                            if (c_valid[i] && c_rank[i] > r0) c_rank[i]--;
                        if (c_occ > 0) c_occ--;
                    end
                end
                fs = -1;
                for (i = 0; i < N_ENT; i++)
                    if (fs < 0 && !c_valid[i]) fs = i;
                if (fs >= 0) begin
                    for (i = 0; i < N_ENT; i++)
                        if (c_valid[i]) c_rank[i]++;
                    c_valid[fs] = 1'b1;
                    c_key[fs] = k;
                    c_data[fs] = v;
                    c_count[fs] = CNT_W'(1);
                    c_rank[fs] = 4'd0;
                    c_occ++;
                end
            end
        end
        r.hit = found;
        return r;
    endfunction

    task automatic send_item(logic op, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v,
                             bit typed, t_rsp want);
        t_rsp pred;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.opcode <= op;
        req_if.key    <= k;
        req_if.value  <= v;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        pred = cache_access(op, k, v);
        pending_rsp.push_back(typed ? want : pred);
        n_req++;
    endtask

    // only between phases, once every response is back
    task automatic write_reg(int idx, logic [APB_DW-1:0] data);
        req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx * 4);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == int'(REG_CAPACITY)) c_cap = data[CAP_W-1:0];
        n_cfg++;
        // read back through the still-selected address
        @(posedge i_clk);
        if (idx == int'(REG_CAPACITY) && prdata !== APB_DW'(c_cap)) begin
            $error("prdata: expected %0d, got %0d", c_cap, prdata);
            n_err++;
        end
    endtask

    // response side back-pressure, with one long hold while requests keep coming
    initial begin
        rsp_if.ready = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                rsp_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left = hold_left - 1;
            end else if (!hold_done && n_rsp >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            n_rsp++;
            if (rsp_if.hit) n_hit++;
            if (rsp_if.evicted) n_evict++;
            if (pending_rsp.size() == 0) begin
                $error("response beat with no request outstanding");
                n_err++;
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_if.hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, rsp_if.hit);
                    n_err++;
                end
                if (rsp_if.read_value !== want.read_value) begin
                    $error("read_value: expected %08h, got %08h",
                           want.read_value, rsp_if.read_value);
                    n_err++;
                end
                if (rsp_if.evicted !== want.evicted) begin
                    $error("evicted: expected %0d, got %0d", want.evicted, rsp_if.evicted);
                    n_err++;
                end
                if (rsp_if.evicted_key !== want.evicted_key) begin
                    $error("evicted_key: expected %08h, got %08h",
                           want.evicted_key, rsp_if.evicted_key);
                    n_err++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int n;
        int rep;
        int seg;
        int i;
        int cap_eff;
        int span;
        t_step row;
        logic op;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] key_pool [POOL_N];

        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.opcode = OP_GET;
        req_if.key    = '0;
        req_if.value  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        n_err = 0;
        n_req = 0;
        n_rsp = 0;
        n_hit = 0;
        n_evict = 0;
        n_cfg = 0;
        quiet_cycles = 0;
        src_idle_pct  = 10;
        sink_idle_pct = 65;
        for (i = 0; i < N_ENT; i++) c_valid[i] = 1'b0;
        c_occ = '0;
        c_cap = CAP_RESET;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        for (i = 2; i < POOL_N; i++) key_pool[i] = $urandom;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < DIR_N; n++) begin
            row = DIR_TAB[n];
            if (row.kind == ROW_CFG)
                write_reg(int'(row.key), row.value);
            else
                for (rep = 0; rep < row.reps; rep++)
                    send_item(row.op, row.key, row.value, row.typed, row.want);
        end

        for (seg = 0; seg < N_SEG; seg++) begin
            if (seg < 5) begin
                src_idle_pct  = 10;
                sink_idle_pct = 65;
            end else if (seg < 9) begin
                src_idle_pct  = 65;
                sink_idle_pct = 10;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            write_reg(int'(REG_CAPACITY), ($urandom & ~32'h1F) | SEG_CAP[seg]);
            cap_eff = (SEG_CAP[seg] > N_ENT) ? N_ENT : SEG_CAP[seg];
            // a few more keys than slots keeps hits and evictions both common
            span = cap_eff + 4;
            for (i = 0; i < 4; i++) key_pool[$urandom_range(2, POOL_N - 1)] = $urandom;
            for (n = 0; n < SEG_ITEMS; n++) begin
                op = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 99) < 88)
                    k = key_pool[$urandom_range(0, span - 1)];
                else
                    k = $urandom;
                send_item(op, k, $urandom, 1'b0, MISS);
            end
        end

        req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("%0d requests and %0d register writes, %0d responses compared",
                 n_req, n_cfg, n_rsp);
        $display("%0d hits and %0d evictions seen over capacities 0 to 31, errors: %0d",
                 n_hit, n_evict, n_err);
        if (n_err == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lfu_pkg.sv
rtl/lfu_req_if.sv
rtl/lfu_rsp_if.sv
rtl/lfu_cache_with_lru_ties.sv
verif/tb_lfu_cache_with_lru_ties.sv
